### design/tosg_pkg.sv
// Shared types and constants for the timed output sequence generator.
package tosg_pkg;

   localparam int MAX_STEPS = 32;
   localparam int CHANNELS  = 8;
   localparam int STEP_IW   = $clog2(MAX_STEPS);
   localparam int ADDR_W    = STEP_IW + 1;
   localparam int CH_W      = $clog2(CHANNELS);
   localparam int DEPTH     = 2 * MAX_STEPS;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CALL  = 1'b1;

   // sequence_mode register codes
   localparam logic [1:0] SEQ_IDLE  = 2'd0;
   localparam logic [1:0] SEQ_START = 2'd1;
   localparam logic [1:0] SEQ_COLD  = 2'd2;
   localparam logic [1:0] SEQ_BAD   = 2'd3;

   // step modes
   localparam logic [1:0] EMODE_OFF   = 2'd0;
   localparam logic [1:0] EMODE_ON    = 2'd1;
   localparam logic [1:0] EMODE_PULSE = 2'd2;
   localparam logic [1:0] EMODE_RSVD  = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [23:0] start_ms;
      logic [3:0]  channel;
      logic [15:0] off_ms;
      logic [15:0] on_ms;
   } step_entry_type;

endpackage

### design/timed_output_sequence_generator_core.sv
// Top level: timed output sequence generator with step-table RAM and walk sequencer.
//
// Usage:
//  - Request channel: a word is taken on a rising edge with start high and busy
//    low. req_type selects a step-table write or a control call.
//  - Result channel: one word per request, shown for one cycle with rsp_strobe.
//    The receiver cannot stall; a new request is taken in the strobe cycle.
//  - Config channel: csr_valid/csr_ready (always ready) writes sequence_mode;
//    a code above the cold table is stored as idle. Write only while idle.
//  - Answers: a table write or a call with no table answers in the cycle after
//    acceptance. A call with a table walks the RAM one entry per cycle until
//    the terminator or the last entry; if a terminator was found and its start
//    time is not yet reached, it then visits each channel (a channel with no
//    effective step is skipped, an on/off step is reread from the RAM, a pulsed
//    step is reread and then sent through the bit-serial remainder unit).
//  - Only the last effective step per channel is evaluated: the walk records
//    its table index, and the channel pass rereads that entry from the RAM.
//  - Reset: sequence_mode, active mode and start time clear; the tables keep
//    whatever they held and must be written before use.
module timed_output_sequence_generator_core (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic        req_table_sel,
   input  logic [4:0]  req_entry_index,
   input  logic [3:0]  req_entry_channel,
   input  logic [23:0] req_entry_start_ms,
   input  logic [1:0]  req_entry_mode,
   input  logic [15:0] req_entry_on_ms,
   input  logic [15:0] req_entry_off_ms,
   input  logic        req_first_time,
   input  logic [31:0] req_current_ms,
   // result
   output logic        rsp_strobe,
   output logic [7:0]  rsp_pin_levels,
   output logic        rsp_pins_driven,
   output logic        rsp_sequence_done,
   // config
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);
   import tosg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WALK = 3'd1;
   localparam logic [2:0] ST_END  = 3'd2;
   localparam logic [2:0] ST_CHAN = 3'd3;
   localparam logic [2:0] ST_CHRD = 3'd4;
   localparam logic [2:0] ST_MOD  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          seq_mode_ff, seq_mode_in;
   logic [1:0]          act_ff, act_in;
   logic [31:0]         t0_ff, t0_in;
   logic [31:0]         elapsed_ff, elapsed_in;
   logic                tbl_ff, tbl_in;
   logic [STEP_IW-1:0]  k_ff, k_in;
   logic [STEP_IW-1:0]  kq_ff, kq_in;
   logic                pend_ff, pend_in;
   logic                found_ff, found_in;
   logic [23:0]         term_ff, term_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [CHANNELS-1:0] levels_ff, levels_in;
   logic [STEP_IW-1:0]  eff_idx_ff [CHANNELS];
   logic [STEP_IW-1:0]  eff_idx_in [CHANNELS];
   logic [CHANNELS-1:0] eff_vld_ff, eff_vld_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]          rsp_levels_ff, rsp_levels_in;
   logic                rsp_driven_ff, rsp_driven_in;
   logic                rsp_done_ff, rsp_done_in;

   logic                accept;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   step_entry_type      mem_wr_data;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   step_entry_type      mem_rd_data;

   logic                mod_go;
   logic                mod_done;
   logic [16:0]         mod_rem;
   logic [31:0]         diff;
   logic [16:0]         period;

   logic [31:0]         call_t0;
   logic [1:0]          call_act;
   logic                entry_live;
   logic                adv;
   logic                set_bit;
   logic                bit_val;

   assign accept = start && !busy;

   // --- step table write path ---
   assign mem_wr_en = accept && (req_type == REQ_WRITE)
                      && ({27'd0, req_entry_index} < 32'(MAX_STEPS));
   assign mem_wr_addr = {req_table_sel, req_entry_index[STEP_IW-1:0]};
   always_comb begin
      mem_wr_data.mode     = req_entry_mode;
      mem_wr_data.start_ms = req_entry_start_ms;
      mem_wr_data.channel  = req_entry_channel;
      mem_wr_data.off_ms   = req_entry_off_ms;
      mem_wr_data.on_ms    = req_entry_on_ms;
   end

   tosg_step_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // pulse phase = (elapsed - start) mod (on + off)
   assign diff   = elapsed_ff - {8'd0, mem_rd_data.start_ms};
   assign period = {1'b0, mem_rd_data.on_ms} + {1'b0, mem_rd_data.off_ms};

   tosg_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (mod_go),
      .dividend  (diff),
      .divisor   (period),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // --- config register ---
   assign csr_ready = 1'b1;
   always_comb begin
      seq_mode_in = seq_mode_ff;
      if (csr_valid && csr_ready) begin
         seq_mode_in = (csr_data == SEQ_BAD) ? SEQ_IDLE : csr_data;
      end
   end

   // --- sequencer ---
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      t0_in         = t0_ff;
      elapsed_in    = elapsed_ff;
      tbl_in        = tbl_ff;
      k_in          = k_ff;
      kq_in         = kq_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      term_in       = term_ff;
      ch_in         = ch_ff;
      levels_in     = levels_ff;
      eff_idx_in    = eff_idx_ff;
      eff_vld_in    = eff_vld_ff;
      rsp_strobe_in = 1'b0;
      rsp_levels_in = rsp_levels_ff;
      rsp_driven_in = rsp_driven_ff;
      rsp_done_in   = rsp_done_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = {tbl_ff, k_ff};
      mod_go        = 1'b0;
      adv           = 1'b0;
      set_bit       = 1'b0;
      bit_val       = 1'b0;
      call_t0       = req_first_time ? req_current_ms : t0_ff;
      call_act      = req_first_time ? seq_mode_ff : act_ff;
      // a step counts once its start time is reached and its mode is defined
      entry_live    = (elapsed_ff >= {8'd0, mem_rd_data.start_ms})
                      && (mem_rd_data.mode != EMODE_RSVD);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_WRITE) begin
                  rsp_strobe_in = 1'b1;
                  rsp_levels_in = '0;
                  rsp_driven_in = 1'b0;
                  rsp_done_in   = 1'b0;
               end else begin
                  t0_in  = call_t0;
                  act_in = call_act;
                  if (call_act != SEQ_START && call_act != SEQ_COLD) begin
                     rsp_strobe_in = 1'b1;
                     rsp_levels_in = '0;
                     rsp_driven_in = 1'b0;
                     rsp_done_in   = 1'b1;
                  end else begin
                     elapsed_in = req_current_ms - call_t0;
                     tbl_in     = (call_act == SEQ_COLD);
                     k_in       = '0;
                     pend_in    = 1'b0;
                     found_in   = 1'b0;
                     eff_vld_in = '0;
                     state_in   = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            // read entry k while evaluating entry k-1
            mem_rd_en = 1'b1;
            k_in      = k_ff + 1'b1;
            kq_in     = k_ff;
            pend_in   = 1'b1;
            if (pend_ff) begin
               if (mem_rd_data.channel >= 4'(CHANNELS)) begin
                  found_in = 1'b1;
                  term_in  = mem_rd_data.start_ms;
                  state_in = ST_END;
               end else begin
                  if (entry_live) begin
                     eff_idx_in[mem_rd_data.channel[CH_W-1:0]] = kq_ff;
                     eff_vld_in[mem_rd_data.channel[CH_W-1:0]] = 1'b1;
                  end
                  if (kq_ff == STEP_IW'(MAX_STEPS - 1)) begin
                     state_in = ST_END;
                  end
               end
            end
         end
         ST_END: begin
            if (!found_ff || elapsed_ff >= {8'd0, term_ff}) begin
               rsp_strobe_in = 1'b1;
               rsp_levels_in = '0;
               rsp_driven_in = 1'b1;
               rsp_done_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ch_in     = '0;
               levels_in = '0;
               state_in  = ST_CHAN;
            end
         end
         ST_CHAN: begin
            if (eff_vld_ff[ch_ff]) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = {tbl_ff, eff_idx_ff[ch_ff]};
               state_in    = ST_CHRD;
            end else begin
               adv = 1'b1;
            end
         end
         ST_CHRD: begin
            unique case (mem_rd_data.mode)
               EMODE_OFF: begin
                  set_bit = 1'b1;
                  bit_val = 1'b0;
                  adv     = 1'b1;
               end
               EMODE_ON: begin
                  set_bit = 1'b1;
                  bit_val = 1'b1;
                  adv     = 1'b1;
               end
               EMODE_PULSE: begin
                  if (period == 17'd0) begin
                     set_bit = 1'b1;
                     bit_val = 1'b0;
                     adv     = 1'b1;
                  end else begin
                     mod_go   = 1'b1;
                     state_in = ST_MOD;
                  end
               end
               default: begin
                  adv = 1'b1;
               end
            endcase
         end
         ST_MOD: begin
            if (mod_done) begin
               set_bit = 1'b1;
               bit_val = !(mod_rem >= {1'b0, mem_rd_data.on_ms});
               adv     = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (set_bit) begin
         levels_in[ch_ff] = bit_val;
      end
      if (adv) begin
         if (ch_ff == CH_W'(CHANNELS - 1)) begin
            rsp_strobe_in = 1'b1;
            rsp_levels_in = 8'(levels_in);
            rsp_driven_in = 1'b1;
            rsp_done_in   = 1'b0;
            state_in      = ST_IDLE;
         end else begin
            ch_in    = ch_ff + 1'b1;
            state_in = ST_CHAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seq_mode_ff   <= SEQ_IDLE;
         act_ff        <= SEQ_IDLE;
         t0_ff         <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         eff_vld_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seq_mode_ff   <= seq_mode_in;
         act_ff        <= act_in;
         t0_ff         <= t0_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         eff_vld_ff    <= eff_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff    <= elapsed_in;
      tbl_ff        <= tbl_in;
      k_ff          <= k_in;
      kq_ff         <= kq_in;
      term_ff       <= term_in;
      ch_ff         <= ch_in;
      levels_ff     <= levels_in;
      eff_idx_ff    <= eff_idx_in;
      rsp_levels_ff <= rsp_levels_in;
      rsp_driven_ff <= rsp_driven_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_pin_levels    = rsp_levels_ff;
   assign rsp_pins_driven   = rsp_driven_ff;
   assign rsp_sequence_done = rsp_done_ff;

`ifndef NO_ASSERTIONS
   // every accepted word either keeps the sequencer busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted word neither in work nor answered");

   // a result is only issued on the way back to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer busy");

   // finished or undriven sequences never show a pin on
   a_done_pins_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_sequence_done || !rsp_pins_driven)) |-> (rsp_pin_levels == 8'd0))
      else $error("pins on with sequence done or not driven");

   // the remainder unit only finishes during a pulse evaluation
   a_mod_in_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("remainder done outside pulse evaluation");
`endif

endmodule

### design/tosg_step_mem.sv
// Step table storage: both tables in one synchronous RAM, one write and one read port.
module tosg_step_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tosg_pkg::ADDR_W-1:0]   wr_addr,
   input  tosg_pkg::step_entry_type      wr_data,
   input  logic                          rd_en,
   input  logic [tosg_pkg::ADDR_W-1:0]   rd_addr,
   output tosg_pkg::step_entry_type      rd_data
);
   import tosg_pkg::*;

   step_entry_type mem [DEPTH];
   step_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tosg_mod.sv
// Iterative 32-bit by 17-bit remainder unit, one quotient bit per cycle.
module tosg_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [16:0] remainder
);
   import tosg_pkg::*;

   logic [31:0] dvd_ff, dvd_in;
   logic [16:0] div_ff, div_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[31]};
      if (go) begin
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 17'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[16:0];
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
